// ----- src/ldp_pkg.sv -----
// Shared constants, types and helper functions of the lidar depth projection block.
package ldp_pkg;

  localparam int IMAGE_WIDTH  = 1024;
  localparam int IMAGE_HEIGHT = 512;
  localparam int PIXELS       = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int ADDR_W       = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int X_W          = (IMAGE_WIDTH > 1) ? $clog2(IMAGE_WIDTH) : 1;
  localparam int Y_W          = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;

  localparam int ACT_W      = 2;
  localparam int PT_W       = 24;
  localparam int INT_W      = 17;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int STATUS_W   = 2;
  localparam int VAL_W      = 16;
  localparam int COEF_W     = 32;
  localparam int REG_W      = 64;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int PROD_W     = COEF_W + PT_W;
  localparam int ACC_W      = 58;
  localparam int DIV_W      = 60;
  localparam int DEPTH_FRAC = 24;
  localparam int WORD_W     = 2 * VAL_W;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] coef_regs_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [1:0] {
    ACT_PROJECT = 2'd0,
    ACT_READ    = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OUTSIDE = 2'd0,
    STATUS_NONPOS  = 2'd1,
    STATUS_KEPT    = 2'd2,
    STATUS_DONE    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MAC,
    S_DIVU,
    S_DIVV,
    S_RDREQ,
    S_RD,
    S_CLRPIX,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic              req;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } zb_req_t;

  function automatic logic [ACC_W-1:0] mag(acc_t a);
    logic [ACC_W-1:0] r;
    r = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
    return r;
  endfunction

endpackage

// ----- src/ldp_if.sv -----
// Valid/ready channel interfaces for point actions and their results.
interface ldp_in_if;
  logic                              valid;
  logic                              ready;
  logic [ldp_pkg::ACT_W-1:0]         action;
  logic signed [ldp_pkg::PT_W-1:0]   point_x;
  logic signed [ldp_pkg::PT_W-1:0]   point_y;
  logic signed [ldp_pkg::PT_W-1:0]   point_z;
  logic [ldp_pkg::INT_W-1:0]         point_intensity;
  logic [ldp_pkg::COL_W-1:0]         pixel_col;
  logic [ldp_pkg::ROW_W-1:0]         pixel_row;

  modport source (output valid, action, point_x, point_y, point_z, point_intensity,
                  pixel_col, pixel_row, input ready);
  modport sink (input valid, action, point_x, point_y, point_z, point_intensity,
                pixel_col, pixel_row, output ready);
endinterface

interface ldp_out_if;
  logic                         valid;
  logic                         ready;
  logic [ldp_pkg::STATUS_W-1:0] status;
  logic [ldp_pkg::VAL_W-1:0]    depth_value;
  logic [ldp_pkg::VAL_W-1:0]    intensity_value;

  modport source (output valid, status, depth_value, intensity_value, input ready);
  modport sink (input valid, status, depth_value, intensity_value, output ready);
endinterface

// ----- src/lidar_depth_projection_zbuffer_top.sv -----
// Lidar point projection into a nearest-depth pixel buffer.
// A project transaction runs twelve products through the shared multiplier, then the
// column and row divisions in one radix-2 divider, then a pixel read and, for a nearer
// point, a write. A point with a w of zero skips the divisions and the pixel access.
// Read and clear touch one pixel; an unused action or a pixel outside the image skips it.
// One transaction is in flight at a time; a finished result waits in the output register.
// After reset the pixel memory is swept to zero before input is taken.
module lidar_depth_projection_zbuffer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ldp_in_if.sink                            in_ch,
  ldp_out_if.source                         out_ch,
  input  logic                              cfg_we_i,
  input  logic [ldp_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ldp_pkg::REG_W-1:0]         cfg_data_i
);

  localparam int DEPTH_LSB = ldp_pkg::DEPTH_FRAC;

  ldp_pkg::state_e                   state_q, state_d;
  ldp_pkg::coef_regs_t               coef_q;

  logic [ldp_pkg::ACT_W-1:0]         action_q;
  logic signed [ldp_pkg::PT_W-1:0]   px_q, py_q, pz_q;
  logic [ldp_pkg::INT_W-1:0]         int_q;
  logic [ldp_pkg::DIV_W-1:0]         qu_q;
  logic [ldp_pkg::ADDR_W-1:0]        addr_q;
  logic [ldp_pkg::VAL_W-1:0]         dnew_q;
  logic [ldp_pkg::STATUS_W-1:0]      res_status_q;
  logic [ldp_pkg::VAL_W-1:0]         res_depth_q, res_int_q;
  logic                              out_valid_q;
  logic [ldp_pkg::STATUS_W-1:0]      out_status_q;
  logic [ldp_pkg::VAL_W-1:0]         out_depth_q, out_int_q;

  ldp_pkg::acc_t                     u, v, w, d;
  logic                              mac_start, mac_done;
  logic                              div_start, div_done;
  logic [ldp_pkg::DIV_W-1:0]         div_num, div_den, quo;
  ldp_pkg::zb_req_t                  zb_req;
  logic [ldp_pkg::WORD_W-1:0]        zb_rdata;
  logic                              zb_clearing;

  logic                              accept, out_load;
  logic                              w_zero, neg_u, neg_v, in_image, depth_ok, pix_ok;
  logic [ldp_pkg::ACC_W:0]           dsum;
  logic [ldp_pkg::ACC_W-DEPTH_LSB-1:0] dm;
  logic [ldp_pkg::VAL_W-1:0]         dsat, isat, old_depth;
  logic                              update;
  logic [ldp_pkg::ADDR_W-1:0]        proj_addr, pix_addr;

  ldp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .coef_i  (coef_q),
    .x_i     (px_q),
    .y_i     (py_q),
    .z_i     (pz_q),
    .u_o     (u),
    .v_o     (v),
    .w_o     (w),
    .d_o     (d),
    .done_o  (mac_done)
  );

  ldp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  ldp_zbuf u_zbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (zb_req),
    .rdata_o    (zb_rdata),
    .clearing_o (zb_clearing)
  );

  // Rounded division is (2|n| + |w|) / (2|w|); the sign is applied afterwards.
  always_comb begin
    w_zero    = (w == '0);
    div_num   = ldp_pkg::DIV_W'({ldp_pkg::mag((state_q == ldp_pkg::S_MAC) ? u : v), 1'b0})
              + ldp_pkg::DIV_W'(ldp_pkg::mag(w));
    div_den   = ldp_pkg::DIV_W'({ldp_pkg::mag(w), 1'b0});
    neg_u     = (qu_q != '0) && (u[ldp_pkg::ACC_W-1] != w[ldp_pkg::ACC_W-1]);
    neg_v     = (quo != '0) && (v[ldp_pkg::ACC_W-1] != w[ldp_pkg::ACC_W-1]);
    in_image  = !neg_u && !neg_v && (qu_q < ldp_pkg::DIV_W'(ldp_pkg::IMAGE_WIDTH))
                && (quo < ldp_pkg::DIV_W'(ldp_pkg::IMAGE_HEIGHT));
    dsum      = {1'b0, ldp_pkg::mag(d)} + (ldp_pkg::ACC_W + 1)'(1 << (DEPTH_LSB - 1));
    dm        = dsum[ldp_pkg::ACC_W-1:DEPTH_LSB];
    depth_ok  = !d[ldp_pkg::ACC_W-1] && (dm != '0);
    dsat      = (dm > $bits(dm)'(16'hFFFF)) ? 16'hFFFF : dm[ldp_pkg::VAL_W-1:0];
    isat      = int_q[ldp_pkg::INT_W-1] ? 16'hFFFF : int_q[ldp_pkg::VAL_W-1:0];
    proj_addr = ldp_pkg::ADDR_W'(int'(quo[ldp_pkg::Y_W-1:0]) * ldp_pkg::IMAGE_WIDTH
                                 + int'(qu_q[ldp_pkg::X_W-1:0]));
    pix_ok    = (int'(in_ch.pixel_col) < ldp_pkg::IMAGE_WIDTH)
                && (int'(in_ch.pixel_row) < ldp_pkg::IMAGE_HEIGHT);
    pix_addr  = ldp_pkg::ADDR_W'(int'(in_ch.pixel_row) * ldp_pkg::IMAGE_WIDTH
                                 + int'(in_ch.pixel_col));
    old_depth = zb_rdata[ldp_pkg::WORD_W-1:ldp_pkg::VAL_W];
    update    = (old_depth == '0) || (old_depth > dnew_q);
    accept    = in_ch.valid && in_ch.ready;
    out_load  = (state_q == ldp_pkg::S_RESULT) && (!out_valid_q || out_ch.ready);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldp_pkg::S_CLEAR: begin
        if (!zb_clearing) state_d = ldp_pkg::S_IDLE;
      end
      ldp_pkg::S_IDLE: begin
        if (accept) begin
          case (ldp_pkg::action_e'(in_ch.action))
            ldp_pkg::ACT_PROJECT: state_d = ldp_pkg::S_MAC;
            ldp_pkg::ACT_READ:    state_d = pix_ok ? ldp_pkg::S_RDREQ : ldp_pkg::S_RESULT;
            ldp_pkg::ACT_CLEAR:   state_d = pix_ok ? ldp_pkg::S_CLRPIX : ldp_pkg::S_RESULT;
            default:              state_d = ldp_pkg::S_RESULT;
          endcase
        end
      end
      ldp_pkg::S_MAC: begin
        if (mac_done) state_d = w_zero ? ldp_pkg::S_RESULT : ldp_pkg::S_DIVU;
      end
      ldp_pkg::S_DIVU: begin
        if (div_done) state_d = ldp_pkg::S_DIVV;
      end
      ldp_pkg::S_DIVV: begin
        if (div_done) begin
          state_d = (in_image && depth_ok) ? ldp_pkg::S_RDREQ : ldp_pkg::S_RESULT;
        end
      end
      ldp_pkg::S_RDREQ:  state_d = ldp_pkg::S_RD;
      ldp_pkg::S_RD:     state_d = ldp_pkg::S_RESULT;
      ldp_pkg::S_CLRPIX: state_d = ldp_pkg::S_RESULT;
      ldp_pkg::S_RESULT: begin
        if (out_load) state_d = ldp_pkg::S_IDLE;
      end
      default: state_d = ldp_pkg::S_CLEAR;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ch.ready  = (state_q == ldp_pkg::S_IDLE);
    mac_start    = accept && (ldp_pkg::action_e'(in_ch.action) == ldp_pkg::ACT_PROJECT);
    div_start    = ((state_q == ldp_pkg::S_MAC) && mac_done && !w_zero)
                   || ((state_q == ldp_pkg::S_DIVU) && div_done);
    zb_req.req   = 1'b0;
    zb_req.we    = 1'b0;
    zb_req.addr  = addr_q;
    zb_req.wdata = '0;
    case (state_q)
      ldp_pkg::S_RDREQ: begin
        zb_req.req = 1'b1;
      end
      ldp_pkg::S_RD: begin
        if (ldp_pkg::action_e'(action_q) == ldp_pkg::ACT_PROJECT && update) begin
          zb_req.req   = 1'b1;
          zb_req.we    = 1'b1;
          zb_req.wdata = {dnew_q, isat};
        end
      end
      ldp_pkg::S_CLRPIX: begin
        zb_req.req = 1'b1;
        zb_req.we  = 1'b1;
      end
      default: begin
        zb_req.req = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldp_pkg::S_CLEAR;
      coef_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        coef_q[cfg_idx_i] <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q     <= in_ch.action;
      px_q         <= in_ch.point_x;
      py_q         <= in_ch.point_y;
      pz_q         <= in_ch.point_z;
      int_q        <= in_ch.point_intensity;
      addr_q       <= pix_addr;
      res_status_q <= pix_ok && (in_ch.action == ldp_pkg::ACT_READ
                                 || in_ch.action == ldp_pkg::ACT_CLEAR)
                      ? ldp_pkg::STATUS_DONE : ldp_pkg::STATUS_OUTSIDE;
      res_depth_q  <= '0;
      res_int_q    <= '0;
    end
    if (state_q == ldp_pkg::S_DIVU && div_done) begin
      qu_q <= quo;
    end
    if (state_q == ldp_pkg::S_DIVV && div_done) begin
      addr_q       <= proj_addr;
      dnew_q       <= dsat;
      res_status_q <= !in_image ? ldp_pkg::STATUS_OUTSIDE
                    : (depth_ok ? ldp_pkg::STATUS_DONE : ldp_pkg::STATUS_NONPOS);
    end
    if (state_q == ldp_pkg::S_RD) begin
      if (ldp_pkg::action_e'(action_q) == ldp_pkg::ACT_READ) begin
        res_depth_q <= old_depth;
        res_int_q   <= zb_rdata[ldp_pkg::VAL_W-1:0];
      end else if (!update) begin
        res_status_q <= ldp_pkg::STATUS_KEPT;
      end
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_depth_q  <= res_depth_q;
      out_int_q    <= res_int_q;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.status          = out_status_q;
  assign out_ch.depth_value     = out_depth_q;
  assign out_ch.intensity_value = out_int_q;

`ifndef NO_ASSERTIONS
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> !zb_clearing)
    else $error("input taken while the pixel memory is still being cleared");

  a_mac_done_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> state_q == ldp_pkg::S_MAC)
    else $error("multiplier finished outside of its state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ldp_pkg::S_DIVU || state_q == ldp_pkg::S_DIVV))
    else $error("divider finished outside of a division state");

  a_write_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (zb_req.req && zb_req.we && state_q == ldp_pkg::S_RD)
    |-> $past(state_q) == ldp_pkg::S_RDREQ)
    else $error("pixel update without a preceding read");
`endif

endmodule

// ----- src/ldp_mac.sv -----
// Shared multiplier that evaluates the four projection rows over twelve products.
module ldp_mac (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  ldp_pkg::coef_regs_t             coef_i,
  input  logic signed [ldp_pkg::PT_W-1:0] x_i,
  input  logic signed [ldp_pkg::PT_W-1:0] y_i,
  input  logic signed [ldp_pkg::PT_W-1:0] z_i,
  output ldp_pkg::acc_t                   u_o,
  output ldp_pkg::acc_t                   v_o,
  output ldp_pkg::acc_t                   w_o,
  output ldp_pkg::acc_t                   d_o,
  output logic                            done_o
);

  logic                                issue_q;
  logic [1:0]                          row_q;
  logic [1:0]                          term_q;
  logic                                prod_vld_q;
  logic                                prod_last_q;
  logic [1:0]                          prod_row_q;
  logic                                done_q;
  logic signed [ldp_pkg::PROD_W-1:0]   prod_q;
  ldp_pkg::acc_t                       acc_q [4];

  logic [ldp_pkg::REG_IDX_W-1:0]       sel;
  logic [ldp_pkg::REG_W-1:0]           word;
  logic signed [ldp_pkg::COEF_W-1:0]   cf;
  logic signed [ldp_pkg::PT_W-1:0]     pt;
  logic signed [ldp_pkg::PROD_W-1:0]   product;
  logic                                last;

  always_comb begin
    sel  = {row_q, (term_q == 2'd2)};
    word = coef_i[sel];
    cf   = (term_q == 2'd1) ? word[ldp_pkg::REG_W-1:ldp_pkg::COEF_W]
                            : word[ldp_pkg::COEF_W-1:0];
    case (term_q)
      2'd0:    pt = x_i;
      2'd1:    pt = y_i;
      default: pt = z_i;
    endcase
    product = cf * pt;
    last    = (row_q == 2'd3) && (term_q == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      row_q       <= 2'd0;
      term_q      <= 2'd0;
      prod_vld_q  <= 1'b0;
      prod_last_q <= 1'b0;
      prod_row_q  <= 2'd0;
      done_q      <= 1'b0;
    end else begin
      done_q     <= prod_vld_q && prod_last_q;
      prod_vld_q <= issue_q;
      if (start_i) begin
        issue_q <= 1'b1;
        row_q   <= 2'd0;
        term_q  <= 2'd0;
      end else if (issue_q) begin
        prod_row_q  <= row_q;
        prod_last_q <= last;
        if (term_q == 2'd2) begin
          term_q <= 2'd0;
          row_q  <= row_q + 2'd1;
        end else begin
          term_q <= term_q + 2'd1;
        end
        if (last) begin
          issue_q <= 1'b0;
        end
      end
    end
  end

  // The offset enters first, scaled from Q16.16 to the Q.24 accumulator.
  always_ff @(posedge clk_i) begin
    if (issue_q) begin
      prod_q <= product;
    end
    if (start_i) begin
      for (int r = 0; r < 4; r++) begin
        acc_q[r] <= {{(ldp_pkg::ACC_W-ldp_pkg::COEF_W-8){coef_i[2*r+1][ldp_pkg::REG_W-1]}},
                     coef_i[2*r+1][ldp_pkg::REG_W-1:ldp_pkg::COEF_W], 8'd0};
      end
    end else if (prod_vld_q) begin
      acc_q[prod_row_q] <= acc_q[prod_row_q] + ldp_pkg::ACC_W'(prod_q);
    end
  end

  assign u_o    = acc_q[0];
  assign v_o    = acc_q[1];
  assign w_o    = acc_q[2];
  assign d_o    = acc_q[3];
  assign done_o = done_q;

endmodule

// ----- src/ldp_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module ldp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ldp_pkg::DIV_W-1:0]  num_i,
  input  logic [ldp_pkg::DIV_W-1:0]  den_i,
  output logic [ldp_pkg::DIV_W-1:0]  quo_o,
  output logic                       done_o
);

  localparam int CNT_W = $clog2(ldp_pkg::DIV_W + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [ldp_pkg::DIV_W:0]     rem_q;
  logic [ldp_pkg::DIV_W-1:0]   quo_q;
  logic [ldp_pkg::DIV_W-1:0]   den_q;

  logic [ldp_pkg::DIV_W:0]     trial;
  logic                        ge;

  always_comb begin
    trial = {rem_q[ldp_pkg::DIV_W-1:0], quo_q[ldp_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ldp_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[ldp_pkg::DIV_W-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ----- src/ldp_zbuf.sv -----
// Pixel memory holding depth and intensity per pixel, with a clearing pass after reset.
module ldp_zbuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ldp_pkg::zb_req_t              req_i,
  output logic [ldp_pkg::WORD_W-1:0]    rdata_o,
  output logic                          clearing_o
);

  logic [ldp_pkg::WORD_W-1:0] mem_q [ldp_pkg::PIXELS];
  logic [ldp_pkg::WORD_W-1:0] rdata_q;
  logic                       clearing_q;
  logic [ldp_pkg::ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + ldp_pkg::ADDR_W'(1);
      if (clr_addr_q == ldp_pkg::ADDR_W'(ldp_pkg::PIXELS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (req_i.req && req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.req && !req_i.we) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule
